### rtl/flat_field_radiometric_correct_unit_assert.svh
// Assertion macros shared by the checker of the radiometric correction unit
`ifndef FLAT_FIELD_RADIOMETRIC_CORRECT_UNIT_ASSERT_SVH
`define FLAT_FIELD_RADIOMETRIC_CORRECT_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante (needs clk and rst in scope)
`define FFRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define FFRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffrc_pkg.sv
// Shared constants, types and codes of the radiometric correction unit
package ffrc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int PIX_W   = 16;   // signed raw pixel
  localparam int MAGIN_W = 16;   // pixel magnitude, up to 32768
  localparam int GAIN_W  = 24;   // flat gain
  localparam int COEF_W  = 32;   // scale factors and offset
  localparam int MAG_W   = 62;   // saturated intermediate magnitude
  localparam int WIDE_W  = 64;   // signed intermediate
  localparam int OUT_W   = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAG_W-1:0]  MAG_LIMIT   = '1;
  localparam logic [OUT_W-1:0]  OUT_MAX     = '1;
  localparam logic [COEF_W-1:0] RECIP_RESET = 32'h0001_0000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESP_RECIP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DN_OFFSET   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RECIP = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    CLIP_NONE = 2'd0,
    CLIP_HIGH = 2'd1,
    CLIP_LOW  = 2'd2
  } clip_t;

  // Sign and magnitude of an intermediate value
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } smag_t;

endpackage

### rtl/ffrc_in_if.sv
// Pixel request channel of the radiometric correction unit
interface ffrc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ffrc_pkg::PIX_W-1:0] pixel_dn;
  logic [ffrc_pkg::GAIN_W-1:0]       flat_gain;
  logic                              flat_present;

  modport source (output valid, pixel_dn, flat_gain, flat_present, input ready);
  modport sink   (input valid, pixel_dn, flat_gain, flat_present, output ready);
endinterface

### rtl/ffrc_out_if.sv
// Corrected pixel channel of the radiometric correction unit
interface ffrc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ffrc_pkg::OUT_W-1:0]  corrected_dn;
  logic [1:0]                  clip_status;

  modport source (output valid, corrected_dn, clip_status, input ready);
  modport sink   (input valid, corrected_dn, clip_status, output ready);
endinterface

### rtl/ffrc_div_pipe.sv
// Pipelined restoring divider: pixel magnitude times 2^(2F) over the flat gain
module ffrc_div_pipe #(
  parameter int FRAC_BITS = ffrc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [ffrc_pkg::PIX_W-1:0] pixel_dn,
  input  logic [ffrc_pkg::GAIN_W-1:0]       flat_gain,
  input  logic                              flat_present,
  input  logic                              flat_enable,
  output logic                              out_valid,
  output ffrc_pkg::smag_t                   out_val
);

  localparam int MAGIN_W = ffrc_pkg::MAGIN_W;
  localparam int GAIN_W  = ffrc_pkg::GAIN_W;
  localparam int MAG_W   = ffrc_pkg::MAG_W;
  localparam int WIDE_W  = ffrc_pkg::WIDE_W;
  localparam int QW      = MAGIN_W + 2 * FRAC_BITS;   // one stage per quotient bit

  logic [MAGIN_W-1:0] pix_raw;
  logic               pix_neg;
  logic [MAGIN_W-1:0] pix_mag;
  logic               pix_div;

  logic               f_valid;
  logic               f_neg;
  logic               f_div;
  logic [MAGIN_W-1:0] f_mag;
  logic [GAIN_W-1:0]  f_gain;

  logic [QW-1:0]      s_valid;
  logic [QW-1:0]      s_neg;
  logic [QW-1:0]      s_div;
  logic [MAGIN_W-1:0] s_mag  [QW];
  logic [GAIN_W-1:0]  s_gain [QW];
  logic [GAIN_W-1:0]  s_rem  [QW];
  logic [QW-1:0]      s_quo  [QW];

  logic [WIDE_W-1:0]  quo_wide;
  logic [MAG_W-1:0]   amag_div;
  logic [MAG_W-1:0]   amag_pass;

  // Take the pixel apart into sign and magnitude, decide on flat division
  always_comb begin
    pix_raw = pixel_dn;
    pix_neg = pix_raw[MAGIN_W-1];
    pix_mag = pix_neg ? (~pix_raw + MAGIN_W'(1)) : pix_raw;
    pix_div = flat_enable & flat_present & (flat_gain != '0);
  end

  // Front register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_neg  <= pix_neg;
      f_div  <= pix_div;
      f_mag  <= pix_mag;
      f_gain <= flat_gain;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_stg
    localparam int BIT = QW - 1 - k;

    logic               pvalid;
    logic               pneg;
    logic               pdiv;
    logic               dbit;
    logic               ge;
    logic [MAGIN_W-1:0] pmag;
    logic [GAIN_W-1:0]  pgain;
    logic [GAIN_W-1:0]  prem;
    logic [GAIN_W-1:0]  nrem;
    logic [QW-1:0]      pquo;
    logic [GAIN_W:0]    trial;

    if (k == 0) begin : g_first
      assign pvalid = f_valid;
      assign pneg   = f_neg;
      assign pdiv   = f_div;
      assign pmag   = f_mag;
      assign pgain  = f_gain;
      assign prem   = '0;
      assign pquo   = '0;
    end else begin : g_next
      assign pvalid = s_valid[k-1];
      assign pneg   = s_neg[k-1];
      assign pdiv   = s_div[k-1];
      assign pmag   = s_mag[k-1];
      assign pgain  = s_gain[k-1];
      assign prem   = s_rem[k-1];
      assign pquo   = s_quo[k-1];
    end

    // Dividend bits below 2F are zero
    if (BIT >= 2 * FRAC_BITS) begin : g_dbit
      assign dbit = pmag[BIT - 2 * FRAC_BITS];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end

    // Compare and subtract
    always_comb begin
      trial = {prem, dbit};
      ge    = trial >= {1'b0, pgain};
      nrem  = ge ? GAIN_W'(trial - {1'b0, pgain}) : trial[GAIN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[k] <= 1'b0;
      end else if (en) begin
        s_valid[k] <= pvalid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_neg[k]  <= pneg;
        s_div[k]  <= pdiv;
        s_mag[k]  <= pmag;
        s_gain[k] <= pgain;
        s_rem[k]  <= nrem;
        s_quo[k]  <= {pquo[QW-2:0], ge};
      end
    end
  end

  // Saturate the quotient, or scale the magnitude when no flat applies
  always_comb begin
    quo_wide  = WIDE_W'(s_quo[QW-1]);
    amag_div  = (quo_wide > WIDE_W'(ffrc_pkg::MAG_LIMIT)) ? ffrc_pkg::MAG_LIMIT
                                                           : quo_wide[MAG_W-1:0];
    amag_pass = MAG_W'(s_mag[QW-1]) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_valid[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val.neg <= s_neg[QW-1];
      out_val.mag <= s_div[QW-1] ? amag_div : amag_pass;
    end
  end

endmodule

### rtl/ffrc_mul_sat.sv
// Two-stage saturating fixed-point multiply of a magnitude by a Q factor
module ffrc_mul_sat #(
  parameter int FRAC_BITS = ffrc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  ffrc_pkg::smag_t              in_val,
  input  logic [ffrc_pkg::COEF_W-1:0]  coef,
  output logic                         out_valid,
  output ffrc_pkg::smag_t              out_val
);

  localparam int MAG_W  = ffrc_pkg::MAG_W;
  localparam int WIDE_W = ffrc_pkg::WIDE_W;
  localparam int COEF_W = ffrc_pkg::COEF_W;
  localparam int LO_W   = WIDE_W / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int SH     = LO_W - FRAC_BITS;
  localparam logic [HI_W+COEF_W-1:0] HI_LIM = (HI_W + COEF_W)'(ffrc_pkg::MAG_LIMIT >> SH);

  logic                     p_valid;
  logic                     p_neg;
  logic [HI_W+COEF_W-1:0]   p_hi;
  logic [LO_W+COEF_W-1:0]   p_lo;

  logic                     hi_sat;
  logic [WIDE_W-1:0]        sum;
  logic                     sat;

  // Stage 1: partial products of the upper and lower halves
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_neg <= in_val.neg;
      p_hi  <= in_val.mag[MAG_W-1:LO_W] * coef;
      p_lo  <= in_val.mag[LO_W-1:0] * coef;
    end
  end

  // Stage 2: align, add and saturate
  always_comb begin
    hi_sat = p_hi > HI_LIM;
    sum    = (WIDE_W'(p_hi) << SH) + WIDE_W'(p_lo >> FRAC_BITS);
    sat    = hi_sat || (sum > WIDE_W'(ffrc_pkg::MAG_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val.neg <= p_neg;
      out_val.mag <= sat ? ffrc_pkg::MAG_LIMIT : sum[MAG_W-1:0];
    end
  end

endmodule

### rtl/ffrc_offset.sv
// Offset subtraction with magnitude clamp, three stages
module ffrc_offset (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  ffrc_pkg::smag_t                     in_val,
  input  logic signed [ffrc_pkg::COEF_W-1:0]  dn_offset,
  output logic                                out_valid,
  output ffrc_pkg::smag_t                     out_val
);

  localparam int MAG_W  = ffrc_pkg::MAG_W;
  localparam int WIDE_W = ffrc_pkg::WIDE_W;

  logic                     v1;
  logic                     v2;
  logic signed [WIDE_W-1:0] b_val;
  logic signed [WIDE_W-1:0] diff;
  logic signed [WIDE_W-1:0] off_wide;
  logic [WIDE_W-1:0]        diff_abs;
  logic [WIDE_W-1:0]        mag_wide;

  assign off_wide = WIDE_W'(dn_offset);
  assign mag_wide = WIDE_W'(in_val.mag);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Signed value, then difference
  always_ff @(posedge clk) begin
    if (en) begin
      b_val <= in_val.neg ? -$signed(mag_wide) : $signed(mag_wide);
      diff  <= b_val - off_wide;
    end
  end

  // Back to sign and magnitude, clamp the magnitude
  always_comb begin
    diff_abs = diff[WIDE_W-1] ? WIDE_W'(-diff) : WIDE_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val.neg <= diff[WIDE_W-1];
      out_val.mag <= (diff_abs > WIDE_W'(ffrc_pkg::MAG_LIMIT)) ? ffrc_pkg::MAG_LIMIT
                                                               : diff_abs[MAG_W-1:0];
    end
  end

endmodule

### rtl/ffrc_round_clip.sv
// Round half up, clip to the output range and hold the result for the sink
module ffrc_round_clip #(
  parameter int FRAC_BITS = ffrc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ffrc_pkg::smag_t   in_val,
  output logic              adv,
  ffrc_out_if.source        out_ch
);

  localparam int OUT_W  = ffrc_pkg::OUT_W;
  localparam int WIDE_W = ffrc_pkg::WIDE_W;
  localparam logic [WIDE_W-1:0] HALF     = WIDE_W'(1) << (FRAC_BITS - 1);
  localparam logic [WIDE_W-1:0] HIGH_LIM = WIDE_W'(ffrc_pkg::OUT_MAX) << FRAC_BITS;

  logic                res_valid;
  logic [OUT_W-1:0]    res_dn;
  ffrc_pkg::clip_t     res_status;

  logic [WIDE_W-1:0]   mag_wide;
  logic [WIDE_W-1:0]   t_pos;
  logic                load;
  logic [OUT_W-1:0]    dn_next;
  ffrc_pkg::clip_t     status_next;

  // Advance the pipeline unless a waiting result would be overwritten
  assign adv  = !in_valid || !res_valid || out_ch.ready;
  assign load = adv && in_valid;

  // A negative value adds the half against its magnitude
  always_comb begin
    mag_wide = WIDE_W'(in_val.mag);
    t_pos    = mag_wide + HALF;
    priority if (in_val.neg && (mag_wide > HALF)) begin
      dn_next     = '0;
      status_next = ffrc_pkg::CLIP_LOW;
    end else if (in_val.neg) begin
      dn_next     = '0;
      status_next = ffrc_pkg::CLIP_NONE;
    end else if (t_pos > HIGH_LIM) begin
      dn_next     = ffrc_pkg::OUT_MAX;
      status_next = ffrc_pkg::CLIP_HIGH;
    end else begin
      dn_next     = t_pos[FRAC_BITS +: OUT_W];
      status_next = ffrc_pkg::CLIP_NONE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_dn     <= dn_next;
      res_status <= status_next;
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.corrected_dn = res_dn;
  assign out_ch.clip_status  = res_status;

endmodule

### rtl/flat_field_radiometric_correct_unit.sv
// Throughput: one pixel per cycle; depth is set by the divider, one quotient bit per stage.
// Back pressure stalls the whole pipeline; a waiting result does not block input
// while the stage in front of the output register is empty.
// Reset clears all valid bits and loads the register defaults (flat use on, unity factors).
module flat_field_radiometric_correct_unit #(
  parameter int FRAC_BITS = ffrc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  ffrc_in_if.sink                             in_ch,
  ffrc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ffrc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ffrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                                 flat_enable;
  logic [ffrc_pkg::COEF_W-1:0]          responsivity_recip;
  logic signed [ffrc_pkg::COEF_W-1:0]   dn_offset;
  logic [ffrc_pkg::COEF_W-1:0]          scale_recip;

  logic                                 adv;
  logic                                 a_valid;
  logic                                 b_valid;
  logic                                 c_valid;
  logic                                 d_valid;
  ffrc_pkg::smag_t                      a_val;
  ffrc_pkg::smag_t                      b_val;
  ffrc_pkg::smag_t                      c_val;
  ffrc_pkg::smag_t                      d_val;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_enable        <= 1'b1;
      responsivity_recip <= ffrc_pkg::RECIP_RESET;
      dn_offset          <= '0;
      scale_recip        <= ffrc_pkg::RECIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ffrc_pkg::REG_FLAT_ENABLE: flat_enable        <= cfg_data[0];
        ffrc_pkg::REG_RESP_RECIP:  responsivity_recip <= cfg_data;
        ffrc_pkg::REG_DN_OFFSET:   dn_offset          <= cfg_data;
        ffrc_pkg::REG_SCALE_RECIP: scale_recip        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = adv;

  // Flat-field division
  ffrc_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (in_ch.valid),
    .pixel_dn     (in_ch.pixel_dn),
    .flat_gain    (in_ch.flat_gain),
    .flat_present (in_ch.flat_present),
    .flat_enable  (flat_enable),
    .out_valid    (a_valid),
    .out_val      (a_val)
  );

  // Responsivity scaling
  ffrc_mul_sat #(.FRAC_BITS(FRAC_BITS)) u_mul_resp (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (a_valid),
    .in_val    (a_val),
    .coef      (responsivity_recip),
    .out_valid (b_valid),
    .out_val   (b_val)
  );

  // Offset
  ffrc_offset u_off (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .in_val    (b_val),
    .dn_offset (dn_offset),
    .out_valid (c_valid),
    .out_val   (c_val)
  );

  // DN scaling
  ffrc_mul_sat #(.FRAC_BITS(FRAC_BITS)) u_mul_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .in_val    (c_val),
    .coef      (scale_recip),
    .out_valid (d_valid),
    .out_val   (d_val)
  );

  // Rounding, clipping and output register
  ffrc_round_clip #(.FRAC_BITS(FRAC_BITS)) u_rnd (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_val   (d_val),
    .adv      (adv),
    .out_ch   (out_ch)
  );

endmodule

### rtl/ffrc_checker.sv
// Port-level checker of the radiometric correction unit and its bind
`include "flat_field_radiometric_correct_unit_assert.svh"

module ffrc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ffrc_pkg::OUT_W-1:0]  corrected_dn,
  input logic [1:0]                  clip_status
);

  // A stalled result holds
  `FFRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(corrected_dn) && $stable(clip_status), "stalled result changed")

  // Clipped high means full scale
  `FFRC_ASSERT_NOW(a_clip_high, out_valid && (clip_status == ffrc_pkg::CLIP_HIGH), corrected_dn == ffrc_pkg::OUT_MAX, "high clip without full scale")

  // Clipped low means zero
  `FFRC_ASSERT_NOW(a_clip_low, out_valid && (clip_status == ffrc_pkg::CLIP_LOW), corrected_dn == '0, "low clip without zero")

  // With no result waiting, requests are taken
  `FFRC_ASSERT_NOW(a_ready_free, in_valid && !out_valid, in_ready, "input stalled with empty output")

endmodule

bind flat_field_radiometric_correct_unit ffrc_checker u_ffrc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .corrected_dn (out_ch.corrected_dn),
  .clip_status  (out_ch.clip_status)
);
